// ===== sv/png_unf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared types and constants of the PNG scanline unfilter: filter codes,
// register map, configuration widths and the per-sample control word.
// ----------------------------------------------------------------------------
package png_unf_pkg;

	localparam int MAX_WIDTH_DEF           = 1024;
	localparam int MAX_BYTES_PER_PIXEL_DEF = 4;

	localparam int IMAGE_WIDTH_W     = 11;
	localparam int IMAGE_HEIGHT_W    = 16;
	localparam int BYTES_PER_PIXEL_W = 3;
	localparam int CFG_ADDR_W        = 4;
	localparam int CFG_DATA_W        = 32;

	typedef enum logic [2:0] {
		FILTER_NONE    = 3'd0,
		FILTER_SUB     = 3'd1,
		FILTER_UP      = 3'd2,
		FILTER_AVERAGE = 3'd3,
		FILTER_PAETH   = 3'd4
	} filter_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_BYTES_PER_PIXEL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		filter_t filter;
		logic    bad;
		logic    first_row;
		logic    first_pixel;
		logic    row_end;
		logic    image_end;
	} sample_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/png_scanline_unfilter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction for 8-bit samples, no interlace.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, filter bytes and samples alike, unless
// the output register is full and stalled. A filter byte produces no
// output; each sample is held in the predictor stage, then in the output
// register. The row store is read once at intake and written once as the
// sample leaves the predictor. It needs no clearing: the first row of each
// image reads the row above as zero. Program image_width, image_height and
// bytes_per_pixel only while the block is idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
	parameter int MAX_WIDTH           = png_unf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_BYTES_PER_PIXEL = png_unf_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [png_unf_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [png_unf_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [png_unf_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                    pready,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [7:0]                         filtered_byte,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [7:0]                         pixel_byte,
	output logic                                    row_end,
	output logic                                    image_end,
	output logic                                    bad_filter
);

	localparam int ROW_STORE = MAX_WIDTH * MAX_BYTES_PER_PIXEL;
	localparam int AW        = (ROW_STORE > 1) ? $clog2(ROW_STORE) : 1;
	localparam int RBW       = $clog2(ROW_STORE + 1);
	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int BW        = $clog2(MAX_BYTES_PER_PIXEL + 1);
	localparam int SW        = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
	localparam int HW        = png_unf_pkg::IMAGE_HEIGHT_W;

	// configuration
	logic [png_unf_pkg::IMAGE_WIDTH_W-1:0]     image_width_q;
	logic [HW-1:0]                             image_height_q;
	logic [png_unf_pkg::BYTES_PER_PIXEL_W-1:0] bytes_per_pixel_q;
	logic                                      cfg_wr;
	png_unf_pkg::reg_idx_t                     cfg_idx;

	logic [WW-1:0]  width_eff;
	logic [BW-1:0]  bpp_eff;
	logic [HW-1:0]  height_eff;
	logic [RBW-1:0] row_bytes;

	// intake
	logic                 expect_filter_q;
	logic [AW-1:0]        col_q;
	logic [1:0]           mod3_q;
	logic [SW-1:0]        slot;
	logic                 first_pixel;
	logic [HW-1:0]        row_q;
	logic                 first_row_q;
	png_unf_pkg::filter_t filter_q;
	logic                 bad_q;
	logic                 in_acc;
	logic                 sample_acc;
	logic                 last_in_row;
	logic                 last_image;

	// predictor stage
	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic [AW-1:0]             col_s1;
	logic [SW-1:0]             slot_s1;
	png_unf_pkg::sample_ctrl_t ctrl_s1;
	logic                      adv_s1;
	logic [7:0]                rd_data;
	logic [7:0]                up_b;
	logic [7:0]                left_a;
	logic [7:0]                upleft_c;
	logic [7:0]                val;

	logic [7:0] left_q   [MAX_BYTES_PER_PIXEL];
	logic [7:0] upleft_q [MAX_BYTES_PER_PIXEL];

	// output register
	logic [7:0] pixel_byte_q;
	logic       row_end_q;
	logic       image_end_q;
	logic       bad_filter_q;
	logic       out_valid_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = png_unf_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= png_unf_pkg::IMAGE_WIDTH_W'(1);
			image_height_q    <= HW'(1);
			bytes_per_pixel_q <= png_unf_pkg::BYTES_PER_PIXEL_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				png_unf_pkg::REG_IMAGE_WIDTH:
					image_width_q <= pwdata[png_unf_pkg::IMAGE_WIDTH_W-1:0];
				png_unf_pkg::REG_IMAGE_HEIGHT:
					image_height_q <= pwdata[HW-1:0];
				png_unf_pkg::REG_BYTES_PER_PIXEL:
					bytes_per_pixel_q <= pwdata[png_unf_pkg::BYTES_PER_PIXEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			png_unf_pkg::REG_IMAGE_WIDTH:
				prdata = png_unf_pkg::CFG_DATA_W'(image_width_q);
			png_unf_pkg::REG_IMAGE_HEIGHT:
				prdata = png_unf_pkg::CFG_DATA_W'(image_height_q);
			png_unf_pkg::REG_BYTES_PER_PIXEL:
				prdata = png_unf_pkg::CFG_DATA_W'(bytes_per_pixel_q);
			default:
				prdata = '0;
		endcase
	end

	always_comb begin
		if (image_width_q == '0) begin
			width_eff = WW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(image_width_q);
		end
		if (bytes_per_pixel_q == '0) begin
			bpp_eff = BW'(1);
		end else if (32'(bytes_per_pixel_q) > MAX_BYTES_PER_PIXEL) begin
			bpp_eff = BW'(MAX_BYTES_PER_PIXEL);
		end else begin
			bpp_eff = BW'(bytes_per_pixel_q);
		end
		height_eff = (image_height_q == '0) ? HW'(1) : image_height_q;
		row_bytes  = RBW'(32'(width_eff) * 32'(bpp_eff));
	end

	// window slot and first-pixel flag follow the current pixel size
	always_comb begin
		case (32'(bpp_eff))
			32'd2:   slot = SW'(col_q[0]);
			32'd3:   slot = SW'(mod3_q);
			32'd4:   slot = SW'(col_q);
			default: slot = '0;
		endcase
		first_pixel = 32'(col_q) < 32'(bpp_eff);
	end

	assign adv_s1     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !adv_s1;
	assign in_acc     = in_valid && !in_stall;
	assign sample_acc = in_acc && !expect_filter_q;

	assign last_in_row = (RBW'(col_q) + RBW'(1)) >= row_bytes;
	assign last_image  = last_in_row && ((17'(row_q) + 17'd1) >= 17'(height_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_filter_q <= 1'b1;
			col_q           <= '0;
			mod3_q          <= '0;
			row_q           <= '0;
			first_row_q     <= 1'b1;
			filter_q        <= png_unf_pkg::FILTER_NONE;
			bad_q           <= 1'b0;
		end else if (in_acc) begin
			if (expect_filter_q) begin
				expect_filter_q <= 1'b0;
				if (filtered_byte > 8'(png_unf_pkg::FILTER_PAETH)) begin
					bad_q    <= 1'b1;
					filter_q <= png_unf_pkg::FILTER_NONE;
				end else begin
					bad_q    <= 1'b0;
					filter_q <= png_unf_pkg::filter_t'(filtered_byte[2:0]);
				end
			end else if (last_in_row) begin
				expect_filter_q <= 1'b1;
				col_q           <= '0;
				mod3_q          <= '0;
				if (last_image) begin
					row_q       <= '0;
					first_row_q <= 1'b1;
				end else begin
					row_q       <= row_q + HW'(1);
					first_row_q <= 1'b0;
				end
			end else begin
				col_q  <= col_q + AW'(1);
				mod3_q <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			byte_s1                 <= filtered_byte;
			col_s1                  <= col_q;
			slot_s1                 <= slot;
			ctrl_s1.filter          <= filter_q;
			ctrl_s1.bad             <= bad_q;
			ctrl_s1.first_row       <= first_row_q;
			ctrl_s1.first_pixel     <= first_pixel;
			ctrl_s1.row_end         <= last_in_row;
			ctrl_s1.image_end       <= last_image;
		end
	end

	png_unf_row_store #(
		.DEPTH (ROW_STORE),
		.AW    (AW)
	) u_row_store (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (val),
		.rd_en   (sample_acc),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	assign up_b     = ctrl_s1.first_row   ? 8'd0 : rd_data;
	assign left_a   = ctrl_s1.first_pixel ? 8'd0 : left_q[slot_s1];
	assign upleft_c = ctrl_s1.first_pixel ? 8'd0 : upleft_q[slot_s1];

	png_unf_predict u_predict (
		.filter (ctrl_s1.filter),
		.x      (byte_s1),
		.a      (left_a),
		.b      (up_b),
		.c      (upleft_c),
		.val    (val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (adv_s1) begin
			left_q[slot_s1]   <= val;
			upleft_q[slot_s1] <= up_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pixel_byte_q <= val;
			row_end_q    <= ctrl_s1.row_end;
			image_end_q  <= ctrl_s1.image_end;
			bad_filter_q <= ctrl_s1.bad;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_byte_q;
	assign row_end    = row_end_q;
	assign image_end  = image_end_q;
	assign bad_filter = bad_filter_q;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("intake stalled with an empty predictor stage");

	a_image_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!image_end || row_end))
		else $error("image end without row end");

	a_filter_wait_clean: assert property (@(posedge clk) disable iff (!arst_n)
		expect_filter_q |-> (col_q == '0 && mod3_q == '0))
		else $error("row counters not cleared while awaiting filter byte");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(col_s1) && $stable(byte_s1)))
		else $error("predictor stage lost a held sample");

endmodule
`default_nettype wire

// ===== sv/png_unf_row_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_row_store
// Previous-row sample store: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module png_unf_row_store #(
	parameter int DEPTH = png_unf_pkg::MAX_WIDTH_DEF * png_unf_pkg::MAX_BYTES_PER_PIXEL_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/png_unf_predict.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_predict
// Sample reconstruction: None, Sub, Up, Average and Paeth predictors,
// result added to the filtered byte modulo 256.
// ----------------------------------------------------------------------------
module png_unf_predict (
	input  wire png_unf_pkg::filter_t filter,
	input  wire logic [7:0]           x,
	input  wire logic [7:0]           a,
	input  wire logic [7:0]           b,
	input  wire logic [7:0]           c,
	output logic      [7:0]           val
);

	logic signed [10:0] d_bc;
	logic signed [10:0] d_ac;
	logic signed [10:0] d_abc;
	logic        [9:0]  pa;
	logic        [9:0]  pb;
	logic        [9:0]  pc;
	logic        [7:0]  paeth;
	logic        [8:0]  sum_ab;
	logic        [7:0]  pred;

	always_comb begin
		d_bc  = $signed({3'b000, b}) - $signed({3'b000, c});
		d_ac  = $signed({3'b000, a}) - $signed({3'b000, c});
		d_abc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
		pa    = d_bc[10]  ? 10'(-d_bc)  : 10'(d_bc);
		pb    = d_ac[10]  ? 10'(-d_ac)  : 10'(d_ac);
		pc    = d_abc[10] ? 10'(-d_abc) : 10'(d_abc);
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
		sum_ab = {1'b0, a} + {1'b0, b};
		case (filter)
			png_unf_pkg::FILTER_SUB:     pred = a;
			png_unf_pkg::FILTER_UP:      pred = b;
			png_unf_pkg::FILTER_AVERAGE: pred = sum_ab[8:1];
			png_unf_pkg::FILTER_PAETH:   pred = paeth;
			default:                     pred = 8'd0;
		endcase
		val = x + pred;
	end

endmodule
`default_nettype wire
